[rtl/core/wtrm_pkg.sv]
// Shared constants for the world-to-region tile mapper.
// No dependencies; used by the top level and the testbench.
package wtrm_pkg;

  localparam int unsigned EDGE_W = 11;
  localparam int unsigned SIDE_W = 9;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned LOC_W  = 8;
  localparam int unsigned LIM_W  = 2 * SIDE_W;

  localparam logic [EDGE_W-1:0] EDGE_MAX = EDGE_W'(1024);
  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(256);

  typedef enum logic [IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_TILE_EDGE    = 3'd2,
    REG_TILES_REGION = 3'd3,
    REG_REGIONS_WIDE = 3'd4,
    REG_REGIONS_HIGH = 3'd5
  } cfg_reg_t;

  typedef logic [EDGE_W-1:0] edge_t;
  typedef logic [SIDE_W-1:0] side_t;

endpackage

[rtl/core/world_to_region_tile_mapper_unit.sv]
// Top level of the world-to-region tile mapper.
// Depends on wtrm_pkg and wtrm_div.
//
// Usage:
//   Input channel: an item (in_op, in_pos_x, in_pos_y) is taken at every
//   rising edge with start high; busy is always low, so one item can enter
//   in every cycle.
//   Result channel: out_valid is high for exactly one cycle per item with
//   the region, local tile, global tile and both map flags.
//   Pipeline: input register, offset stage, tile divider of COORD_BITS
//   stages, sign fixup stage, region divider of COORD_BITS stages, output
//   register. Throughput: one item per cycle.
//   Each divider retires one quotient bit per stage.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index;
//   write only while no item is in flight.
//   Reset: all valid bits clear, registers return to origin 0 and all
//   sizes 1. The receiver cannot stall; the pipeline always advances.
module world_to_region_tile_mapper_unit #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic                         cfg_we,
  input  logic [wtrm_pkg::IDX_W-1:0]   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_wdata,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_region_col,
  output logic signed [COORD_BITS-1:0] out_region_row,
  output logic [wtrm_pkg::LOC_W-1:0]   out_local_tile_col,
  output logic [wtrm_pkg::LOC_W-1:0]   out_local_tile_row,
  output logic signed [COORD_BITS-1:0] out_global_tile_col,
  output logic signed [COORD_BITS-1:0] out_global_tile_row,
  output logic                         out_region_valid,
  output logic                         out_tile_valid
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned W   = COORD_BITS + 1;
  localparam int unsigned EW  = wtrm_pkg::EDGE_W;
  localparam int unsigned SW  = wtrm_pkg::SIDE_W;
  localparam int unsigned LW  = wtrm_pkg::LIM_W;
  localparam int unsigned XW  = W + LW;

  // configuration
  logic [CB-1:0]       org_x_r, org_y_r;
  wtrm_pkg::edge_t     edge_raw_r, edge_r;
  wtrm_pkg::side_t     tpr_raw_r, rw_raw_r, rh_raw_r;
  wtrm_pkg::side_t     tpr_r, rw_r, rh_r;
  logic [LW-1:0]       lim_x_r, lim_y_r;

  function automatic wtrm_pkg::side_t clamp_side(input wtrm_pkg::side_t v);
    if (v == '0) begin
      return SW'(1);
    end else if (v > wtrm_pkg::SIDE_MAX) begin
      return wtrm_pkg::SIDE_MAX;
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r    <= '0;
      org_y_r    <= '0;
      edge_raw_r <= EW'(1);
      tpr_raw_r  <= SW'(1);
      rw_raw_r   <= SW'(1);
      rh_raw_r   <= SW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        wtrm_pkg::REG_ORIGIN_X:     org_x_r    <= cfg_wdata;
        wtrm_pkg::REG_ORIGIN_Y:     org_y_r    <= cfg_wdata;
        wtrm_pkg::REG_TILE_EDGE:    edge_raw_r <= cfg_wdata[EW-1:0];
        wtrm_pkg::REG_TILES_REGION: tpr_raw_r  <= cfg_wdata[SW-1:0];
        wtrm_pkg::REG_REGIONS_WIDE: rw_raw_r   <= cfg_wdata[SW-1:0];
        wtrm_pkg::REG_REGIONS_HIGH: rh_raw_r   <= cfg_wdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (edge_raw_r == '0) begin
      edge_r <= EW'(1);
    end else if (edge_raw_r > wtrm_pkg::EDGE_MAX) begin
      edge_r <= wtrm_pkg::EDGE_MAX;
    end else begin
      edge_r <= edge_raw_r;
    end
    tpr_r   <= clamp_side(tpr_raw_r);
    rw_r    <= clamp_side(rw_raw_r);
    rh_r    <= clamp_side(rh_raw_r);
    lim_x_r <= LW'(rw_r) * LW'(tpr_r);
    lim_y_r <= LW'(rh_r) * LW'(tpr_r);
  end

  assign busy = 1'b0;

  // input register
  logic          vld0_r, op0_r;
  logic [CB-1:0] px0_r, py0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    op0_r <= in_op;
    px0_r <= in_pos_x;
    py0_r <= in_pos_y;
  end

  // offset by origin (in_op low only)
  logic          vlda_r, opa_r;
  logic [W-1:0]  nx_r, ny_r;
  logic [W-1:0]  nx_nxt, ny_nxt;

  always_comb begin
    if (op0_r) begin
      nx_nxt = {px0_r[CB-1], px0_r};
      ny_nxt = {py0_r[CB-1], py0_r};
    end else begin
      nx_nxt = {px0_r[CB-1], px0_r} - {org_x_r[CB-1], org_x_r};
      ny_nxt = {py0_r[CB-1], py0_r} - {org_y_r[CB-1], org_y_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlda_r <= 1'b0;
    end else begin
      vlda_r <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    opa_r <= op0_r;
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
  end

  // tile division: negative n maps to floor = ~((~n) / d)
  logic [CB-1:0] magx1, magy1;
  wtrm_pkg::edge_t den1;
  logic          v1x, v1y, s1x, s1y;
  logic [CB-1:0] q1x, q1y;
  logic [EW-1:0] r1x, r1y;

  assign magx1 = nx_r[W-1] ? ~nx_r[CB-1:0] : nx_r[CB-1:0];
  assign magy1 = ny_r[W-1] ? ~ny_r[CB-1:0] : ny_r[CB-1:0];
  assign den1  = opa_r ? EW'(1) : edge_r;

  wtrm_div #(.NUM_W(CB), .DEN_W(EW), .TAG_W(1)) u_div_tx (
    .clk(clk), .rst_n(rst_n),
    .in_vld(vlda_r), .in_num(magx1), .in_den(den1), .in_tag(nx_r[W-1]),
    .out_vld(v1x), .out_quo(q1x), .out_rem(r1x), .out_tag(s1x)
  );

  wtrm_div #(.NUM_W(CB), .DEN_W(EW), .TAG_W(1)) u_div_ty (
    .clk(clk), .rst_n(rst_n),
    .in_vld(vlda_r), .in_num(magy1), .in_den(den1), .in_tag(ny_r[W-1]),
    .out_vld(v1y), .out_quo(q1y), .out_rem(r1y), .out_tag(s1y)
  );

  // global tile
  logic          vldb_r;
  logic [W-1:0]  gx_r, gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldb_r <= 1'b0;
    end else begin
      vldb_r <= v1x & v1y;
    end
  end

  always_ff @(posedge clk) begin
    gx_r <= s1x ? ~{1'b0, q1x} : {1'b0, q1x};
    gy_r <= s1y ? ~{1'b0, q1y} : {1'b0, q1y};
  end

  // region division
  logic [CB-1:0] magx2, magy2;
  logic          v2x, v2y;
  logic [CB-1:0] q2x, q2y;
  logic [SW-1:0] r2x, r2y;
  logic [W-1:0]  g2x, g2y;

  assign magx2 = gx_r[W-1] ? ~gx_r[CB-1:0] : gx_r[CB-1:0];
  assign magy2 = gy_r[W-1] ? ~gy_r[CB-1:0] : gy_r[CB-1:0];

  wtrm_div #(.NUM_W(CB), .DEN_W(SW), .TAG_W(W)) u_div_rx (
    .clk(clk), .rst_n(rst_n),
    .in_vld(vldb_r), .in_num(magx2), .in_den(tpr_r), .in_tag(gx_r),
    .out_vld(v2x), .out_quo(q2x), .out_rem(r2x), .out_tag(g2x)
  );

  wtrm_div #(.NUM_W(CB), .DEN_W(SW), .TAG_W(W)) u_div_ry (
    .clk(clk), .rst_n(rst_n),
    .in_vld(vldb_r), .in_num(magy2), .in_den(tpr_r), .in_tag(gy_r),
    .out_vld(v2y), .out_quo(q2y), .out_rem(r2y), .out_tag(g2y)
  );

  // final fixup, flags and saturation
  function automatic logic [CB-1:0] sat(input logic [W-1:0] v);
    if (v[W-1] != v[W-2]) begin
      return v[W-1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    end
    return v[CB-1:0];
  endfunction

  logic [W-1:0]  rx, ry;
  logic [SW-1:0] lx, ly;
  logic          rvalid_nxt, tvalid_nxt;

  always_comb begin
    rx = g2x[W-1] ? ~{1'b0, q2x} : {1'b0, q2x};
    ry = g2y[W-1] ? ~{1'b0, q2y} : {1'b0, q2y};
    lx = g2x[W-1] ? (tpr_r - SW'(1) - r2x) : r2x;
    ly = g2y[W-1] ? (tpr_r - SW'(1) - r2y) : r2y;
    rvalid_nxt = !rx[W-1] && !ry[W-1]
              && ({{LW{1'b0}}, rx} < {{(XW-SW){1'b0}}, rw_r})
              && ({{LW{1'b0}}, ry} < {{(XW-SW){1'b0}}, rh_r});
    tvalid_nxt = !g2x[W-1] && !g2y[W-1]
              && (XW'(g2x) < {{W{1'b0}}, lim_x_r})
              && (XW'(g2y) < {{W{1'b0}}, lim_y_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2x & v2y;
    end
  end

  always_ff @(posedge clk) begin
    out_region_col      <= sat(rx);
    out_region_row      <= sat(ry);
    out_local_tile_col  <= lx[wtrm_pkg::LOC_W-1:0];
    out_local_tile_row  <= ly[wtrm_pkg::LOC_W-1:0];
    out_global_tile_col <= sat(g2x);
    out_global_tile_row <= sat(g2y);
    out_region_valid    <= rvalid_nxt;
    out_tile_valid      <= tvalid_nxt;
  end

endmodule

[rtl/core/wtrm_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Uses wtrm_pkg only through its callers' widths; carries a tag per item.
module wtrm_div #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 11,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [NUM_W-1:0] out_quo,
  output logic [DEN_W-1:0] out_rem,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld_r [NUM_W+1];
  logic [NUM_W-1:0] num_r [NUM_W+1];
  logic [NUM_W-1:0] quo_r [NUM_W+1];
  logic [DEN_W-1:0] rem_r [NUM_W+1];
  logic [DEN_W-1:0] den_r [NUM_W+1];
  logic [TAG_W-1:0] tag_r [NUM_W+1];

  assign vld_r[0] = in_vld;
  assign num_r[0] = in_num;
  assign quo_r[0] = '0;
  assign rem_r[0] = '0;
  assign den_r[0] = in_den;
  assign tag_r[0] = in_tag;

  for (genvar g = 0; g < NUM_W; g++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           fits;
    logic [DEN_W:0] diff_nxt;

    assign trial    = {rem_r[g], num_r[g][NUM_W-1]};
    assign fits     = trial >= {1'b0, den_r[g]};
    assign diff_nxt = fits ? (trial - {1'b0, den_r[g]}) : trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      num_r[g+1] <= num_r[g] << 1;
      quo_r[g+1] <= {quo_r[g][NUM_W-2:0], fits};
      rem_r[g+1] <= diff_nxt[DEN_W-1:0];
      den_r[g+1] <= den_r[g];
      tag_r[g+1] <= tag_r[g];
    end
  end

  assign out_vld = vld_r[NUM_W];
  assign out_quo = quo_r[NUM_W];
  assign out_rem = rem_r[NUM_W];
  assign out_tag = tag_r[NUM_W];

endmodule

[tb/sv/testbench.sv]
// Testbench for world_to_region_tile_mapper_unit: directed and random items
// checked against a predictor of the tile mapping. Depends on wtrm_pkg.
`timescale 1ns / 1ps
module testbench;

  localparam int CB = 24;
  localparam int LATENCY = 2 * CB + 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [CB-1:0] region_col;
    logic signed [CB-1:0] region_row;
    logic [7:0]           local_col;
    logic [7:0]           local_row;
    logic signed [CB-1:0] global_col;
    logic signed [CB-1:0] global_row;
    logic                 region_ok;
    logic                 tile_ok;
  } tile_map_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic in_op = 0;
  logic signed [CB-1:0] in_pos_x = '0;
  logic signed [CB-1:0] in_pos_y = '0;
  logic cfg_we = 0;
  logic [wtrm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [CB-1:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [CB-1:0] out_region_col, out_region_row;
  logic [wtrm_pkg::LOC_W-1:0] out_local_tile_col, out_local_tile_row;
  logic signed [CB-1:0] out_global_tile_col, out_global_tile_row;
  logic out_region_valid, out_tile_valid;

  world_to_region_tile_mapper_unit #(.COORD_BITS(CB)) dut (.*);

  initial forever #5 clk = ~clk;

  longint org_x, org_y;
  longint edge_reg, tpr_reg, rw_reg, rh_reg;
  tile_map_t pending_maps[$];
  int fail_count = 0;
  int idle_cycles = 0;

  function automatic longint clamp_size(longint v, longint hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint fdiv(longint n, longint d, output longint r);
    longint q;
    q = n / d;
    r = n % d;
    if (r < 0) begin
      r += d;
      q -= 1;
    end
    return q;
  endfunction

  function automatic logic [CB-1:0] sat(longint v);
    longint hi;
    hi = (longint'(1) <<< (CB - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[CB-1:0];
  endfunction

  function automatic tile_map_t map_position(logic op, logic signed [CB-1:0] px,
                                             logic signed [CB-1:0] py);
    tile_map_t m;
    longint ed, tp, rw, rh, gx, gy, rx, ry, lx, ly, junk;
    ed = clamp_size(edge_reg, 1024);
    tp = clamp_size(tpr_reg, 256);
    rw = clamp_size(rw_reg, 256);
    rh = clamp_size(rh_reg, 256);
    if (!op) begin
      gx = fdiv(longint'(px) - org_x, ed, junk);
      gy = fdiv(longint'(py) - org_y, ed, junk);
    end else begin
      gx = px;
      gy = py;
    end
    rx = fdiv(gx, tp, lx);
    ry = fdiv(gy, tp, ly);
    m.region_col = sat(rx);
    m.region_row = sat(ry);
    m.local_col = lx[7:0];
    m.local_row = ly[7:0];
    m.global_col = sat(gx);
    m.global_row = sat(gy);
    m.region_ok = rx >= 0 && rx < rw && ry >= 0 && ry < rh;
    m.tile_ok = gx >= 0 && gx < rw * tp && gy >= 0 && gy < rh * tp;
    return m;
  endfunction

  task automatic write_reg(wtrm_pkg::cfg_reg_t idx, logic [CB-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      wtrm_pkg::REG_ORIGIN_X: org_x = longint'($signed(val));
      wtrm_pkg::REG_ORIGIN_Y: org_y = longint'($signed(val));
      wtrm_pkg::REG_TILE_EDGE: edge_reg = val[10:0];
      wtrm_pkg::REG_TILES_REGION: tpr_reg = val[8:0];
      wtrm_pkg::REG_REGIONS_WIDE: rw_reg = val[8:0];
      default: rh_reg = val[8:0];
    endcase
  endtask

  task automatic drain();
    start <= 0;
    while (pending_maps.size() != 0) @(negedge clk);
  endtask

  task automatic set_map(logic [CB-1:0] ox, logic [CB-1:0] oy, logic [CB-1:0] ed,
                         logic [CB-1:0] tp, logic [CB-1:0] rw, logic [CB-1:0] rh);
    drain();
    write_reg(wtrm_pkg::REG_ORIGIN_X, ox);
    write_reg(wtrm_pkg::REG_ORIGIN_Y, oy);
    write_reg(wtrm_pkg::REG_TILE_EDGE, ed);
    write_reg(wtrm_pkg::REG_TILES_REGION, tp);
    write_reg(wtrm_pkg::REG_REGIONS_WIDE, rw);
    write_reg(wtrm_pkg::REG_REGIONS_HIGH, rh);
  endtask

  // Hold start over back-to-back items; drop it only before an idle gap.
  task automatic send_item(logic op, logic [CB-1:0] px, logic [CB-1:0] py, int gap);
    start <= 1;
    in_op <= op;
    in_pos_x <= px;
    in_pos_y <= py;
    do @(posedge clk); while (busy);
    pending_maps.push_back(map_position(op, px, py));
    @(negedge clk);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic int draw_gap(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [CB-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return CB'($urandom);
      1: return CB'($signed($urandom_range(0, 4000)) - 2000);
      2: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
      default: return CB'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  always @(posedge clk) begin
    tile_map_t e, a;
    if (rst_n && out_valid) begin
      a = '{out_region_col, out_region_row, out_local_tile_col, out_local_tile_row,
            out_global_tile_col, out_global_tile_row, out_region_valid, out_tile_valid};
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected item, actual %h", $time, a);
        fail_count++;
      end else begin
        e = pending_maps.pop_front();
        if (e.region_col != a.region_col || e.region_row != a.region_row ||
            e.local_col != a.local_col || e.local_row != a.local_row ||
            e.global_col != a.global_col || e.global_row != a.global_row ||
            e.region_ok != a.region_ok || e.tile_ok != a.tile_ok) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, a);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_item(0, 0, 0, 0);
    send_item(1, 5, -3, 2);
    send_item(0, {1'b1, {(CB-1){1'b0}}}, {1'b0, {(CB-1){1'b1}}}, 0);
  endtask

  task automatic test_directed();
    set_map(-100, 50, 16, 8, 4, 3);
    send_item(0, -100, 50, 0);
    send_item(0, -116, 34, 0);
    send_item(0, -101, 49, 3);
    send_item(1, -8, -16, 0);
    send_item(1, 31, 23, 0);
    send_item(1, 32, 24, 1);
    set_map({1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}}, 1, 1, 256, 256);
    send_item(0, {1'b1, {(CB-1){1'b0}}}, {1'b0, {(CB-1){1'b1}}}, 0);
    send_item(0, {1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}}, 0);
    set_map(0, 0, 0, 0, 0, 0);
    send_item(0, 3, -3, 0);
    send_item(1, 0, 0, 0);
    set_map(7, -7, 2047, 511, 511, 300);
    send_item(0, 5000, -5000, 0);
    send_item(1, 65535, 65536, 0);
    send_item(1, -1, -65536, 0);
    set_map(0, 0, 1024, 256, 256, 256);
    send_item(0, -1, -1024, 0);
    send_item(1, 65535, -65537, 0);
    send_item(0, {1'b0, {(CB-1){1'b1}}}, 0, 0);
  endtask

  task automatic test_random(int phases, int per_phase);
    bit burst;
    for (int p = 0; p < phases; p++) begin
      set_map(rand_coord(), rand_coord(), CB'($urandom_range(0, 2047)),
              CB'($urandom_range(0, 511)), CB'($urandom_range(0, 511)),
              CB'($urandom_range(0, 511)));
      for (int i = 0; i < per_phase; i++) begin
        burst = (i / 16) % 3 == 0;
        send_item(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), draw_gap(burst));
      end
    end
  endtask

  initial begin
    org_x = 0; org_y = 0; edge_reg = 1; tpr_reg = 1; rw_reg = 1; rh_reg = 1;
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    test_reset_defaults();
    test_directed();
    test_random(15, 50);
    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0 && pending_maps.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

[sim.f]
rtl/core/wtrm_pkg.sv
rtl/core/wtrm_div.sv
rtl/core/world_to_region_tile_mapper_unit.sv
tb/sv/testbench.sv
